### hdl/fdt_pkg.sv
// Shared constants for the fixed-point to decimal text converter.
package fdt_pkg;

    localparam int VALUE_BITS       = 49;
    localparam int CNT_W            = $clog2(VALUE_BITS + 1);
    localparam int FRAC_DIGITS_DEF  = 5;
    localparam int INT_DIGITS_DEF   = 10;
    localparam int CHAR_W           = 8;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

endpackage

### hdl/fdt_dabble_unit.sv
// Shared add-3 and shift step for binary to BCD conversion, one bit per use.
module fdt_dabble_unit
    import fdt_pkg::*;
#(
    parameter int NUM_DIGITS = INT_DIGITS_DEF + FRAC_DIGITS_DEF
)
(
    input  logic [4*NUM_DIGITS-1:0] bcd,
    input  logic                    bit_in,
    output logic [4*NUM_DIGITS-1:0] bcd_shifted,
    output logic                    carry
);

    logic [4*NUM_DIGITS-1:0] adj;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd[4*i +: 4] >= 4'd5)
                adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = bcd[4*i +: 4];
        end
    end

    assign {carry, bcd_shifted} = {adj, bit_in};

endmodule

### hdl/fixed_to_decimal_text.sv
// Top level: signed fixed-point value to decimal ASCII text, one character per item.
// From input accept to first character valid: conversion of all VALUE_BITS magnitude bits,
// a fix-up step, up to INT_DIGITS-1 leading-zero skips and a skip exit, then the output load.
// A new value is accepted only after the last character of the previous value is loaded.
// The bit-serial add-3/shift unit sets the conversion time; output stalls hold the emit state.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
module fixed_to_decimal_text
    import fdt_pkg::*;
#(
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF,
    parameter int INT_DIGITS  = INT_DIGITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [VALUE_BITS-1:0] value_scaled,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [CHAR_W-1:0]       out_char,
    output logic                    last
);

    localparam int NUM_DIGITS = INT_DIGITS + FRAC_DIGITS;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int FRAC_W     = 4 * FRAC_DIGITS;
    localparam int IL_W       = $clog2(INT_DIGITS + 1);
    localparam int FL_W       = $clog2(FRAC_DIGITS + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_FIX  = 5'b00100,
        ST_SKIP = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_BITS-1:0]  mag_reg, mag_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic                   ovf_reg, ovf_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [IL_W-1:0]        int_left_reg, int_left_next;
    logic [FL_W-1:0]        frac_left_reg, frac_left_next;
    logic                   sign_pend_reg, sign_pend_next;
    logic                   dot_pend_reg, dot_pend_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      out_char_reg, out_char_next;
    logic                   last_reg, last_next;

    logic [BCD_W-1:0]       bcd_step;
    logic                   step_carry;
    logic [BCD_W-1:0]       bcd_sat;
    logic [BCD_W-1:0]       bcd_digit_shift;
    logic [3:0]             top_digit;
    logic [CHAR_W-1:0]      top_char;
    logic                   can_load;

    fdt_dabble_unit #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dabble (
        .bcd         (bcd_reg),
        .bit_in      (mag_reg[VALUE_BITS-1]),
        .bcd_shifted (bcd_step),
        .carry       (step_carry)
    );

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
            bcd_sat[4*i +: 4] = 4'd9;
    end

    assign top_digit       = bcd_reg[BCD_W-1 -: 4];
    assign top_char        = CHAR_ZERO + {4'd0, top_digit};
    assign bcd_digit_shift = {bcd_reg[BCD_W-5:0], 4'd0};
    assign can_load        = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        ovf_next       = ovf_reg;
        cnt_next       = cnt_reg;
        int_left_next  = int_left_reg;
        frac_left_next = frac_left_reg;
        sign_pend_next = sign_pend_reg;
        dot_pend_next  = dot_pend_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_char_next  = out_char_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sign_pend_next = value_scaled[VALUE_BITS-1];
                    mag_next       = value_scaled[VALUE_BITS-1] ?
                                     (~value_scaled + 1'b1) : value_scaled;
                    bcd_next       = '0;
                    ovf_next       = 1'b0;
                    cnt_next       = CNT_W'(VALUE_BITS);
                    state_next     = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next = bcd_step;
                ovf_next = ovf_reg | step_carry;
                mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    state_next = ST_FIX;
            end
            ST_FIX:
            begin
                bcd_next       = ovf_reg ? bcd_sat : bcd_reg;
                dot_pend_next  = ovf_reg || (|bcd_reg[FRAC_W-1:0]);
                int_left_next  = IL_W'(INT_DIGITS);
                frac_left_next = FL_W'(FRAC_DIGITS);
                state_next     = ST_SKIP;
            end
            ST_SKIP:
            begin
                if (int_left_reg > IL_W'(1) && top_digit == 4'd0)
                begin
                    bcd_next      = bcd_digit_shift;
                    int_left_next = int_left_reg - 1'b1;
                end
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    if (sign_pend_reg)
                    begin
                        out_char_next  = CHAR_MINUS;
                        last_next      = 1'b0;
                        sign_pend_next = 1'b0;
                    end
                    else if (int_left_reg != '0)
                    begin
                        out_char_next = top_char;
                        last_next     = (int_left_reg == IL_W'(1)) && !dot_pend_reg;
                        bcd_next      = bcd_digit_shift;
                        int_left_next = int_left_reg - 1'b1;
                        if ((int_left_reg == IL_W'(1)) && !dot_pend_reg)
                            state_next = ST_IDLE;
                    end
                    else if (dot_pend_reg)
                    begin
                        out_char_next = CHAR_DOT;
                        last_next     = 1'b0;
                        dot_pend_next = 1'b0;
                    end
                    else
                    begin
                        out_char_next  = top_char;
                        last_next      = (frac_left_reg == FL_W'(1));
                        bcd_next       = bcd_digit_shift;
                        frac_left_next = frac_left_reg - 1'b1;
                        if (frac_left_reg == FL_W'(1))
                            state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            int_left_reg  <= '0;
            frac_left_reg <= '0;
            sign_pend_reg <= 1'b0;
            dot_pend_reg  <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            int_left_reg  <= int_left_next;
            frac_left_reg <= frac_left_next;
            sign_pend_reg <= sign_pend_next;
            dot_pend_reg  <= dot_pend_next;
            ovf_reg       <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

    a_conv_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV && cnt_reg == CNT_W'(1)) |=> (state_reg == ST_FIX))
        else $error("conversion did not end after the last bit");

    a_skip_keeps_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SKIP) |-> (int_left_reg != '0))
        else $error("leading-zero skip dropped every integer digit");

    a_emit_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |->
        (sign_pend_reg || int_left_reg != '0 || (dot_pend_reg && frac_left_reg != '0) ||
         frac_left_reg != '0))
        else $error("emit state with nothing left to send");

endmodule

### verif/fixed_to_decimal_text_tb.sv
// Self-checking testbench for the fixed-point to decimal text converter.
module fixed_to_decimal_text_tb
    import fdt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     IDLE_LIMIT  = 2000;
    localparam int     HOLD_CYCLES = 300;
    localparam int     RANDOM_ITEMS = 350;
    localparam longint VALUE_MAX   = 64'sd214748364799999;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_char_t;

    class text_checker;
        text_char_t expected_text[$];
        int mismatches;
        int values_seen;
        int negatives_seen;
        int whole_seen;
        int chars_checked;

        function new();
            mismatches     = 0;
            values_seen    = 0;
            negatives_seen = 0;
            whole_seen     = 0;
            chars_checked  = 0;
        endfunction

        function int pending();
            return expected_text.size();
        endfunction

        function void note_value(logic signed [VALUE_BITS-1:0] v);
            logic [VALUE_BITS-1:0] mag;
            logic [63:0]           scale;
            logic [63:0]           int_max;
            logic [63:0]           ipart;
            logic [63:0]           fpart;
            logic [3:0]            digs[20];
            logic [CHAR_W-1:0]     line[$];
            int                    nd;
            text_char_t            c;
            scale   = 64'd1;
            int_max = 64'd1;
            for (int i = 0; i < FRAC_DIGITS_DEF; i++)
                scale = scale * 10;
            for (int i = 0; i < INT_DIGITS_DEF; i++)
                int_max = int_max * 10;
            int_max = int_max - 1;
            mag   = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
            ipart = 64'(mag) / scale;
            fpart = 64'(mag) % scale;
            if (ipart > int_max)
            begin
                ipart = int_max;
                fpart = scale - 1;
            end
            values_seen++;
            if (v[VALUE_BITS-1])
            begin
                negatives_seen++;
                line.push_back(CHAR_MINUS);
            end
            nd = 0;
            do
            begin
                digs[nd] = 4'(ipart % 10);
                ipart    = ipart / 10;
                nd++;
            end
            while (ipart != 0 && nd < 20);
            while (nd > 0)
            begin
                nd--;
                line.push_back(CHAR_ZERO + CHAR_W'(digs[nd]));
            end
            if (fpart != 0)
            begin
                line.push_back(CHAR_DOT);
                for (int i = 0; i < FRAC_DIGITS_DEF; i++)
                begin
                    digs[i] = 4'(fpart % 10);
                    fpart   = fpart / 10;
                end
                for (int i = FRAC_DIGITS_DEF - 1; i >= 0; i--)
                    line.push_back(CHAR_ZERO + CHAR_W'(digs[i]));
            end
            else
                whole_seen++;
            foreach (line[i])
            begin
                c.ch   = line[i];
                c.last = (i == line.size() - 1);
                expected_text.push_back(c);
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] ch, logic lst);
            text_char_t want;
            chars_checked++;
            if (expected_text.size() == 0)
            begin
                $display("%0t: unexpected char, expected none, actual '%c' (%h) last %0b",
                         $time, ch, ch, lst);
                mismatches++;
                return;
            end
            want = expected_text.pop_front();
            if (ch !== want.ch)
            begin
                $display("%0t: out_char mismatch, expected '%c' (%h), actual '%c' (%h)",
                         $time, want.ch, want.ch, ch, ch);
                mismatches++;
            end
            if (lst !== want.last)
            begin
                $display("%0t: last mismatch on '%c', expected %0b, actual %0b",
                         $time, want.ch, want.last, lst);
                mismatches++;
            end
        endfunction
    endclass

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         in_valid     = 1'b0;
    logic                         in_stall;
    logic signed [VALUE_BITS-1:0] value_scaled = '0;
    logic                         out_valid;
    logic                         out_stall    = 1'b0;
    logic [CHAR_W-1:0]            out_char;
    logic                         last;

    bit  send_idle    = 1'b1;
    bit  recv_idle    = 1'b1;
    bit  hold_output  = 1'b0;
    int  idle_cycles  = 0;

    text_checker sb = new();

    longint corner_values[24] = '{
        64'sd0, 64'sd1, -64'sd1, 64'sd3, -64'sd3, 64'sd10, 64'sd99999, -64'sd99999,
        64'sd100000, -64'sd100000, 64'sd100001, -64'sd100010, 64'sd123456789,
        -64'sd1234500000, 64'sd214748364799999, -64'sd214748364799999,
        64'sd214748364700000, -64'sd214748364700000, 64'sd140737488355328,
        -64'sd140737488355328, 64'sd100000000000000, 64'sd99999999999999,
        64'sd1000000000, -64'sd5
    };

    fixed_to_decimal_text u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value_scaled (value_scaled),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_char     (out_char),
        .last         (last)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_char(out_char, last);
            if (in_valid && !in_stall)
                sb.note_value(value_scaled);
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d chars still expected",
                         $time, IDLE_LIMIT, sb.pending());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_output)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            n = recv_idle ? $urandom_range(0, 8) : 0;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall))
                @(posedge clk);
        end
    end

    function automatic longint ten_to(int n);
        longint p;
        p = 1;
        for (int i = 0; i < n; i++)
            p = p * 10;
        return p;
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] draw_value();
        logic [63:0] r;
        longint      ip;
        longint      fp;
        longint      m;
        int          nd;
        if ($urandom_range(0, 9) == 0)
        begin
            r = {$urandom(), $urandom()};
            m = longint'(r % 64'(2 * VALUE_MAX + 1)) - VALUE_MAX;
            return m[VALUE_BITS-1:0];
        end
        nd = $urandom_range(0, 10);
        if (nd == 0)
            ip = 0;
        else if (nd == 10)
            ip = longint'($urandom_range(2147483647, 1000000000));
        else
            ip = longint'($urandom_range(32'(ten_to(nd) - 1), 32'(ten_to(nd - 1))));
        case ($urandom_range(0, 3))
            0:       fp = 0;
            1:       fp = longint'($urandom_range(99, 1));
            default: fp = longint'($urandom_range(99999, 0));
        endcase
        m = ip * 100000 + fp;
        if ($urandom_range(0, 1))
            m = -m;
        return m[VALUE_BITS-1:0];
    endfunction

    task automatic send_value(input logic signed [VALUE_BITS-1:0] v);
        int gap;
        gap = send_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        value_scaled <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_text();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int burst_left;
        wait (rst_n);
        @(posedge clk);
        foreach (corner_values[i])
            send_value(corner_values[i][VALUE_BITS-1:0]);
        drain_text();
        burst_left = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 0)
            begin
                send_idle = ($urandom_range(0, 3) != 0);
                recv_idle = ($urandom_range(0, 3) != 0);
            end
            if (i == 100)
            begin
                hold_output = 1'b1;
                burst_left  = 12;
            end
            if (i == 220)
                drain_text();
            if (burst_left > 0)
            begin
                send_idle = 1'b0;
                burst_left--;
            end
            send_value(draw_value());
        end
        drain_text();
        repeat (150) @(posedge clk);
        $display("Converted %0d values (%0d negative, %0d without fraction), %0d chars checked,",
                 sb.values_seen, sb.negatives_seen, sb.whole_seen, sb.chars_checked);
        $display("with corner values, random idles, a long output hold and a full drain pause.");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
